### rtl/tcce_pkg.sv
// Package for the text console cursor engine.
// Holds the item codes, character codes and the input and result item types.
// No dependencies.
`default_nettype none

package tcce_pkg;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_SET   = 2'd2;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LAST  = 8'h7F;

    localparam logic [7:0] ATTR_RESET = 8'h07;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] column;
    } t_in_item;

    typedef struct packed {
        logic        write_valid;
        logic [4:0]  write_row;
        logic [6:0]  write_col;
        logic [7:0]  write_char;
        logic [7:0]  write_attr;
        logic        scroll;
        logic        clear;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_addr;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/text_console_cursor_engine.sv
// Top level of the text console cursor engine: input register, cursor state,
// result register and the attribute register. Uses tcce_pkg and tcce_step.
//
//  Channel  Signals                          Moves
//  in       i_in_valid / o_in_ready          t_in_item: kind, ch, row, column
//  out      o_out_valid / i_out_ready        t_out_item: cell write, flags, cursor
//  cfg      i_cfg_we / i_cfg_data            attribute byte, no wait
//
// An item passes through the input register, then the cursor logic, and its result is
// loaded into the result register once that register is free.
// One item per cycle is sustained while the output is not stalled; the cursor register feedback sets that figure.
// Reset clears the cursor to row 0, column 0 and sets the attribute to 7.
// A stalled output holds its result; the input register takes one more item and then holds it.
`default_nettype none

module text_console_cursor_engine #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  var tcce_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output tcce_pkg::t_out_item   o_out_item,
    input  wire                   i_cfg_we,
    input  wire  [7:0]            i_cfg_data
);
    import tcce_pkg::*;

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);

    logic            r_in_valid;
    t_in_item        r_in_item;
    logic            r_out_valid;
    t_out_item       r_out_item;
    logic [RW-1:0]   r_cur_row;
    logic [CW-1:0]   r_cur_col;
    logic [7:0]      r_attr;

    logic [RW-1:0]   n_cur_row;
    logic [CW-1:0]   n_cur_col;
    t_out_item       n_out_item;

    logic            w_out_free;
    logic            w_advance;
    logic            w_accept;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    tcce_step #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_step (
        .i_item     (r_in_item),
        .i_attr     (r_attr),
        .i_cur_row  (r_cur_row),
        .i_cur_col  (r_cur_col),
        .o_next_row (n_cur_row),
        .o_next_col (n_cur_col),
        .o_result   (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_attr      <= ATTR_RESET;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_cur_row   <= n_cur_row;
                r_cur_col   <= n_cur_col;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= i_in_item;
        end
        if (w_advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

### rtl/tcce_step.sv
// Next-cursor and cell-write logic for one item of the text console cursor engine.
// Purely combinational; uses tcce_pkg.
`default_nettype none

module tcce_step #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  var tcce_pkg::t_in_item             i_item,
    input  wire  [7:0]                         i_attr,
    input  wire  [$clog2(ROWS)-1:0]            i_cur_row,
    input  wire  [$clog2(COLUMNS)-1:0]         i_cur_col,
    output logic [$clog2(ROWS)-1:0]            o_next_row,
    output logic [$clog2(COLUMNS)-1:0]         o_next_col,
    output tcce_pkg::t_out_item                o_result
);
    import tcce_pkg::*;

    localparam int RW   = $clog2(ROWS);
    localparam int CW   = $clog2(COLUMNS);
    localparam int RW1  = $clog2(ROWS + 1);
    localparam int NXW  = $clog2(COLUMNS + TAB_STOP);
    localparam int AW   = $clog2(ROWS * COLUMNS);

    // Next tab stop for every column, fixed at elaboration.
    logic [NXW-1:0] w_tab_next [COLUMNS];

    genvar gi;
    generate
        for (gi = 0; gi < COLUMNS; gi++) begin : g_tab
            assign w_tab_next[gi] = NXW'(gi + TAB_STOP - (gi % TAB_STOP));
        end
    endgenerate

    logic [NXW-1:0] w_col1;
    logic [RW1-1:0] w_row1;
    logic [RW1-1:0] w_row2;
    logic [NXW-1:0] w_col2;
    logic           w_write;
    logic           w_scroll;
    logic           w_clear;
    logic [RW-1:0]  w_row_f;
    logic [CW-1:0]  w_col_f;
    logic [AW-1:0]  w_addr;

    always_comb begin
        w_col1   = NXW'(i_cur_col);
        w_row1   = RW1'(i_cur_row);
        w_row2   = RW1'(i_cur_row);
        w_col2   = NXW'(i_cur_col);
        w_write  = 1'b0;
        w_scroll = 1'b0;
        w_clear  = 1'b0;
        w_row_f  = i_cur_row;
        w_col_f  = i_cur_col;

        unique case (i_item.kind)
            KIND_CHAR: begin
                priority if (i_item.ch == CH_CR) begin
                    w_col1 = '0;
                end else if (i_item.ch == CH_LF) begin
                    w_row1 = RW1'(i_cur_row) + RW1'(1);
                    w_col1 = '0;
                end else if (i_item.ch == CH_BS) begin
                    if (i_cur_col != '0) begin
                        w_col1 = NXW'(i_cur_col) - NXW'(1);
                    end
                end else if (i_item.ch == CH_TAB) begin
                    w_col1 = w_tab_next[i_cur_col];
                end else if (i_item.ch >= CH_SPACE && i_item.ch <= CH_LAST) begin
                    w_write = 1'b1;
                    w_col1  = NXW'(i_cur_col) + NXW'(1);
                end else begin
                    w_col1 = NXW'(i_cur_col);
                end

                // Wrap past the last column, then hold on the bottom row.
                if (32'(w_col1) >= 32'(COLUMNS)) begin
                    w_col2 = '0;
                    w_row2 = w_row1 + RW1'(1);
                end else begin
                    w_col2 = w_col1;
                    w_row2 = w_row1;
                end
                if (32'(w_row2) >= 32'(ROWS)) begin
                    w_scroll = 1'b1;
                    w_row_f  = RW'(ROWS - 1);
                end else begin
                    w_row_f  = RW'(w_row2);
                end
                w_col_f = CW'(w_col2);
            end
            KIND_CLEAR: begin
                w_clear = 1'b1;
                w_row_f = '0;
                w_col_f = '0;
            end
            KIND_SET: begin
                w_row_f = (32'(i_item.row) >= 32'(ROWS)) ? RW'(ROWS - 1) : RW'(i_item.row);
                w_col_f = (32'(i_item.column) >= 32'(COLUMNS)) ? CW'(COLUMNS - 1)
                                                                : CW'(i_item.column);
            end
            default: begin
                w_row_f = i_cur_row;
                w_col_f = i_cur_col;
            end
        endcase
    end

    assign w_addr = AW'(w_row_f) * AW'(COLUMNS) + AW'(w_col_f);

    assign o_next_row = w_row_f;
    assign o_next_col = w_col_f;

    always_comb begin
        o_result             = '0;
        o_result.write_valid = w_write;
        if (w_write) begin
            o_result.write_row  = 5'(i_cur_row);
            o_result.write_col  = 7'(i_cur_col);
            o_result.write_char = i_item.ch;
            o_result.write_attr = i_attr;
        end
        o_result.scroll      = w_scroll;
        o_result.clear       = w_clear;
        o_result.cursor_row  = 5'(w_row_f);
        o_result.cursor_col  = 7'(w_col_f);
        o_result.cursor_addr = 11'(w_addr);
    end

endmodule

`default_nettype wire
